@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the route table block.
// Has no dependencies; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/mrt_pkg.sv @@
// Shared types, operation and status codes for the MAC route table block.
// Has no dependencies; used by every module of the block but mrt_ram.
package mrt_pkg;

   localparam int MAC_W          = 48;
   localparam int TUN_W          = 6;
   localparam int TUNNEL_IDS     = 64;
   localparam int TIME_W         = 32;
   localparam int INTERVAL_W     = 24;
   localparam int OP_W           = 4;
   localparam int STATUS_W       = 2;
   localparam int CNT_W          = 9;
   localparam int QUEUE_DEPTH    = 2;
   localparam int ADJ_ENTRIES_DEF   = 64;
   localparam int ROUTE_ENTRIES_DEF = 256;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd120000;
   localparam logic [CNT_W-1:0]      CNT_MAX        = 9'd511;

   localparam logic [OP_W-1:0] OP_ADD        = 4'd0;
   localparam logic [OP_W-1:0] OP_REMOVE     = 4'd1;
   localparam logic [OP_W-1:0] OP_UPDATE     = 4'd2;
   localparam logic [OP_W-1:0] OP_GET_ROUTE  = 4'd3;
   localparam logic [OP_W-1:0] OP_GET_TUNNEL = 4'd4;
   localparam logic [OP_W-1:0] OP_IS_ADJ     = 4'd5;
   localparam logic [OP_W-1:0] OP_EXISTS     = 4'd6;
   localparam logic [OP_W-1:0] OP_TICK       = 4'd7;
   localparam logic [OP_W-1:0] OP_SCAVENGE   = 4'd8;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [MAC_W-1:0] mac;
      logic [MAC_W-1:0] via;
      logic [TUN_W-1:0] tun;
      logic             adj_scan;
      logic             route_scan;
   } item_type;

endpackage

@@ rtl/core/mrt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Has no dependencies.
module mrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mrt_front.sv @@
// Front end: takes request transfers, classifies the operation and queues it.
// Depends on mrt_pkg.
module mrt_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [mrt_pkg::OP_W-1:0]  req_operation,
   input  logic [mrt_pkg::MAC_W-1:0] req_peer_mac,
   input  logic [mrt_pkg::MAC_W-1:0] req_via_mac,
   input  logic [mrt_pkg::TUN_W-1:0] req_tunnel_id,
   output logic                      q_valid,
   output mrt_pkg::item_type         q_item,
   input  logic                      q_pop
);

   localparam int QW = $clog2(mrt_pkg::QUEUE_DEPTH);

   mrt_pkg::item_type slot_ff [mrt_pkg::QUEUE_DEPTH];
   mrt_pkg::item_type new_item;
   logic [QW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QW:0]       count_ff, count_in;
   logic              push;

   always_comb begin
      new_item.op  = req_operation;
      new_item.mac = req_peer_mac;
      new_item.via = req_via_mac;
      new_item.tun = req_tunnel_id;
      new_item.adj_scan = (req_operation == mrt_pkg::OP_ADD) ||
                          (req_operation == mrt_pkg::OP_REMOVE) ||
                          (req_operation == mrt_pkg::OP_UPDATE) ||
                          (req_operation == mrt_pkg::OP_GET_TUNNEL) ||
                          (req_operation == mrt_pkg::OP_IS_ADJ);
      new_item.route_scan = (req_operation == mrt_pkg::OP_GET_ROUTE) ||
                            (req_operation == mrt_pkg::OP_EXISTS) ||
                            (req_operation == mrt_pkg::OP_SCAVENGE);
   end

   assign req_stall = (count_ff == (QW+1)'(mrt_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ rtl/core/mrt_back.sv @@
// Back end: sweeps the adjacency and route memories, applies the operation
// and holds the response register. Depends on mrt_pkg and mrt_ram.
module mrt_back #(
   parameter int ADJ_ENTRIES   = mrt_pkg::ADJ_ENTRIES_DEF,
   parameter int ROUTE_ENTRIES = mrt_pkg::ROUTE_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  mrt_pkg::item_type              q_item,
   output logic                           q_pop,
   input  logic [mrt_pkg::INTERVAL_W-1:0] interval,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mrt_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_answer,
   output logic [mrt_pkg::TUN_W-1:0]      rsp_found_tunnel,
   output logic [mrt_pkg::CNT_W-1:0]      rsp_removed_count
);

   localparam int AW    = $clog2(ADJ_ENTRIES);
   localparam int RW    = $clog2(ROUTE_ENTRIES);
   localparam int ENT_W = mrt_pkg::MAC_W + mrt_pkg::TUN_W;
   localparam int TW    = mrt_pkg::TIME_W;
   localparam logic [AW:0] ADJ_END   = (AW+1)'(ADJ_ENTRIES);
   localparam logic [RW:0] ROUTE_END = (RW+1)'(ROUTE_ENTRIES);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ADJ   = 4'b0010,
      S_ROUTE = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   mrt_pkg::item_type cur_ff, cur_in;

   logic [AW:0]   a_cnt_ff, a_cnt_in;
   logic          a_pv_ff, a_pv_in;
   logic [AW-1:0] a_pidx_ff, a_pidx_in;
   logic          a_hit_ff, a_hit_in, a_free_ff, a_free_in;
   logic [AW-1:0] a_idx_ff, a_idx_in, a_fidx_ff, a_fidx_in;
   logic [mrt_pkg::TUN_W-1:0] a_tun_ff, a_tun_in;

   logic [RW:0]   r_cnt_ff, r_cnt_in;
   logic          r_pv_ff, r_pv_in;
   logic [RW-1:0] r_pidx_ff, r_pidx_in;
   logic          r_hit_ff, r_hit_in, r_free_ff, r_free_in;
   logic [RW-1:0] r_idx_ff, r_idx_in, r_fidx_ff, r_fidx_in;
   logic [mrt_pkg::TUN_W-1:0] r_tun_ff, r_tun_in;

   logic [mrt_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [TW-1:0]             now_ff, now_in;
   logic [ADJ_ENTRIES-1:0]    adj_used_ff, adj_used_in;
   logic [ROUTE_ENTRIES-1:0]  route_used_ff, route_used_in;
   logic [mrt_pkg::TUNNEL_IDS-1:0] tv_ff, tv_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [mrt_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                           rsp_answer_ff, rsp_answer_in;
   logic [mrt_pkg::TUN_W-1:0]      rsp_found_ff, rsp_found_in;
   logic [mrt_pkg::CNT_W-1:0]      rsp_removed_ff, rsp_removed_in;

   logic             adj_we;
   logic [AW-1:0]    adj_wa;
   logic [ENT_W-1:0] adj_wd, adj_rd;
   logic             rdt_we, rtm_we;
   logic [RW-1:0]    r_wa;
   logic [ENT_W-1:0] rdt_wd, rdt_rd;
   logic [TW-1:0]    rtm_rd;

   logic [mrt_pkg::MAC_W-1:0] adj_key, a_mac, r_mac;
   logic [mrt_pkg::TUN_W-1:0] a_tn, r_tn;
   logic [TW-1:0]             limit, age;
   logic                      out_free, adj_ok;

   mrt_ram #(.WIDTH(ENT_W), .DEPTH(ADJ_ENTRIES)) u_adj_ram (
      .clock(clock), .wr_en(adj_we), .wr_addr(adj_wa), .wr_data(adj_wd),
      .rd_addr(a_cnt_ff[AW-1:0]), .rd_data(adj_rd)
   );

   mrt_ram #(.WIDTH(ENT_W), .DEPTH(ROUTE_ENTRIES)) u_route_ram (
      .clock(clock), .wr_en(rdt_we), .wr_addr(r_wa), .wr_data(rdt_wd),
      .rd_addr(r_cnt_ff[RW-1:0]), .rd_data(rdt_rd)
   );

   mrt_ram #(.WIDTH(TW), .DEPTH(ROUTE_ENTRIES)) u_time_ram (
      .clock(clock), .wr_en(rtm_we), .wr_addr(r_wa), .wr_data(now_ff),
      .rd_addr(r_cnt_ff[RW-1:0]), .rd_data(rtm_rd)
   );

   assign a_mac = adj_rd[ENT_W-1:mrt_pkg::TUN_W];
   assign a_tn  = adj_rd[mrt_pkg::TUN_W-1:0];
   assign r_mac = rdt_rd[ENT_W-1:mrt_pkg::TUN_W];
   assign r_tn  = rdt_rd[mrt_pkg::TUN_W-1:0];
   assign limit = ({{(TW-mrt_pkg::INTERVAL_W){1'b0}}, interval} << 1) +
                  {{(TW-mrt_pkg::INTERVAL_W){1'b0}}, interval};
   assign age   = now_ff - rtm_rd;
   assign adj_key  = (cur_ff.op == mrt_pkg::OP_UPDATE) ? cur_ff.via : cur_ff.mac;
   assign adj_ok   = (cur_ff.mac != cur_ff.via) && a_hit_ff && tv_ff[a_tun_ff];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      a_cnt_in  = a_cnt_ff;   a_pv_in   = 1'b0;     a_pidx_in = a_pidx_ff;
      a_hit_in  = a_hit_ff;   a_idx_in  = a_idx_ff; a_tun_in  = a_tun_ff;
      a_free_in = a_free_ff;  a_fidx_in = a_fidx_ff;
      r_cnt_in  = r_cnt_ff;   r_pv_in   = 1'b0;     r_pidx_in = r_pidx_ff;
      r_hit_in  = r_hit_ff;   r_idx_in  = r_idx_ff; r_tun_in  = r_tun_ff;
      r_free_in = r_free_ff;  r_fidx_in = r_fidx_ff;
      cnt_in        = cnt_ff;
      now_in        = now_ff;
      adj_used_in   = adj_used_ff;
      route_used_in = route_used_ff;
      tv_in         = tv_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_answer_in  = rsp_answer_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_removed_in = rsp_removed_ff;
      q_pop  = 1'b0;
      adj_we = 1'b0;
      adj_wa = a_idx_ff;
      adj_wd = {cur_ff.mac, cur_ff.tun};
      rdt_we = 1'b0;
      rtm_we = 1'b0;
      r_wa   = r_idx_ff;
      rdt_wd = {cur_ff.mac, a_tun_ff};

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               cur_in    = q_item;
               a_cnt_in  = '0;
               a_hit_in  = 1'b0;
               a_free_in = 1'b0;
               r_cnt_in  = '0;
               r_hit_in  = 1'b0;
               r_free_in = 1'b0;
               cnt_in    = '0;
               if (q_item.adj_scan) begin
                  state_in = S_ADJ;
               end else if (q_item.route_scan) begin
                  state_in = S_ROUTE;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_ADJ: begin
            if (a_cnt_ff != ADJ_END) begin
               a_pv_in   = 1'b1;
               a_pidx_in = a_cnt_ff[AW-1:0];
               a_cnt_in  = a_cnt_ff + 1'b1;
            end
            if (a_pv_ff) begin
               if (adj_used_ff[a_pidx_ff] && (a_mac == adj_key) && !a_hit_ff) begin
                  a_hit_in = 1'b1;
                  a_idx_in = a_pidx_ff;
                  a_tun_in = a_tn;
               end
               if (!adj_used_ff[a_pidx_ff] && !a_free_ff) begin
                  a_free_in = 1'b1;
                  a_fidx_in = a_pidx_ff;
               end
            end
            if ((a_cnt_ff == ADJ_END) && !a_pv_ff) begin
               state_in = ((cur_ff.op == mrt_pkg::OP_UPDATE) && adj_ok) ? S_ROUTE : S_DONE;
            end
         end
         S_ROUTE: begin
            if (r_cnt_ff != ROUTE_END) begin
               r_pv_in   = 1'b1;
               r_pidx_in = r_cnt_ff[RW-1:0];
               r_cnt_in  = r_cnt_ff + 1'b1;
            end
            if (r_pv_ff) begin
               if (cur_ff.op == mrt_pkg::OP_SCAVENGE) begin
                  if (route_used_ff[r_pidx_ff] && (!tv_ff[r_tn] || (age > limit))) begin
                     route_used_in[r_pidx_ff] = 1'b0;
                     if (cnt_ff != mrt_pkg::CNT_MAX) begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
               end else begin
                  if (route_used_ff[r_pidx_ff] && (r_mac == cur_ff.mac) && !r_hit_ff) begin
                     r_hit_in = 1'b1;
                     r_idx_in = r_pidx_ff;
                     r_tun_in = r_tn;
                  end
                  if (!route_used_ff[r_pidx_ff] && !r_free_ff) begin
                     r_free_in = 1'b1;
                     r_fidx_in = r_pidx_ff;
                  end
               end
            end
            if ((r_cnt_ff == ROUTE_END) && !r_pv_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = mrt_pkg::ST_OK;
               rsp_answer_in  = 1'b0;
               rsp_found_in   = '0;
               rsp_removed_in = '0;
               case (cur_ff.op)
                  mrt_pkg::OP_ADD: begin
                     if (a_hit_ff || a_free_ff) begin
                        adj_wa = a_hit_ff ? a_idx_ff : a_fidx_ff;
                        adj_we = 1'b1;
                        adj_used_in[adj_wa] = 1'b1;
                        tv_in[cur_ff.tun]   = 1'b1;
                     end else begin
                        rsp_status_in = mrt_pkg::ST_FULL;
                     end
                  end
                  mrt_pkg::OP_REMOVE: begin
                     if (a_hit_ff) begin
                        tv_in[a_tun_ff]       = 1'b0;
                        adj_used_in[a_idx_ff] = 1'b0;
                     end else begin
                        rsp_status_in = mrt_pkg::ST_NOT_FOUND;
                     end
                  end
                  mrt_pkg::OP_UPDATE: begin
                     if (!adj_ok) begin
                        rsp_status_in = mrt_pkg::ST_INVALID;
                     end else if (r_hit_ff || r_free_ff) begin
                        r_wa   = r_hit_ff ? r_idx_ff : r_fidx_ff;
                        rdt_we = 1'b1;
                        rtm_we = 1'b1;
                        route_used_in[r_wa] = 1'b1;
                     end else begin
                        rsp_status_in = mrt_pkg::ST_FULL;
                     end
                  end
                  mrt_pkg::OP_GET_ROUTE: begin
                     if (r_hit_ff) begin
                        rtm_we       = 1'b1;
                        rsp_found_in = r_tun_ff;
                     end else begin
                        rsp_status_in = mrt_pkg::ST_NOT_FOUND;
                     end
                  end
                  mrt_pkg::OP_GET_TUNNEL: begin
                     if (a_hit_ff) begin
                        rsp_found_in = a_tun_ff;
                     end else begin
                        rsp_status_in = mrt_pkg::ST_NOT_FOUND;
                     end
                  end
                  mrt_pkg::OP_IS_ADJ: begin
                     rsp_answer_in = a_hit_ff;
                  end
                  mrt_pkg::OP_EXISTS: begin
                     if (r_hit_ff) begin
                        if (tv_ff[r_tun_ff]) begin
                           rsp_answer_in = 1'b1;
                        end else begin
                           route_used_in[r_idx_ff] = 1'b0;
                        end
                     end
                  end
                  mrt_pkg::OP_TICK: begin
                     now_in = now_ff + 1'b1;
                  end
                  mrt_pkg::OP_SCAVENGE: begin
                     rsp_removed_in = cnt_ff;
                  end
                  default: begin
                     rsp_status_in = mrt_pkg::ST_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         a_pv_ff       <= 1'b0;
         r_pv_ff       <= 1'b0;
         now_ff        <= '0;
         adj_used_ff   <= '0;
         route_used_ff <= '0;
         tv_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         a_pv_ff       <= a_pv_in;
         r_pv_ff       <= r_pv_in;
         now_ff        <= now_in;
         adj_used_ff   <= adj_used_in;
         route_used_ff <= route_used_in;
         tv_ff         <= tv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      a_cnt_ff  <= a_cnt_in;  a_pidx_ff <= a_pidx_in;
      a_hit_ff  <= a_hit_in;  a_idx_ff  <= a_idx_in;  a_tun_ff <= a_tun_in;
      a_free_ff <= a_free_in; a_fidx_ff <= a_fidx_in;
      r_cnt_ff  <= r_cnt_in;  r_pidx_ff <= r_pidx_in;
      r_hit_ff  <= r_hit_in;  r_idx_ff  <= r_idx_in;  r_tun_ff <= r_tun_in;
      r_free_ff <= r_free_in; r_fidx_ff <= r_fidx_in;
      cnt_ff         <= cnt_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_answer_ff  <= rsp_answer_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_answer        = rsp_answer_ff;
   assign rsp_found_tunnel  = rsp_found_ff;
   assign rsp_removed_count = rsp_removed_ff;

endmodule

@@ rtl/core/mac_route_table_with_aging.sv @@
// Sequencing: tick and unknown codes go from the queue straight to the response register;
//   peer operations sweep the adjacency memory, route lookups and scavenge the route memory,
//   and update route sweeps both (the route memory only if the peer check passes), one entry a cycle.
// Concurrency: the back end holds one item at a time; a two-entry queue takes requests meanwhile.
// Reset: synchronous; clears used and valid bits, the clock and the queue at once.
//
// The front end takes request transfers and classifies them by which tables they
// must search. The back end walks the adjacency memory and/or the route memory one
// entry per cycle through a registered read port, remembers the first matching
// entry and the first free entry (scavenge clears stale routes instead), and then
// applies the change while loading the response register. A finished response
// waits in that register while the queue keeps accepting new requests until full.
//
// Depends on mrt_pkg, mrt_front, mrt_back, mrt_ram and assert_macros.svh.
`include "assert_macros.svh"

module mac_route_table_with_aging #(
   parameter int ADJ_ENTRIES   = mrt_pkg::ADJ_ENTRIES_DEF,
   parameter int ROUTE_ENTRIES = mrt_pkg::ROUTE_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [mrt_pkg::INTERVAL_W-1:0] csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mrt_pkg::OP_W-1:0]       req_operation,
   input  logic [mrt_pkg::MAC_W-1:0]      req_peer_mac,
   input  logic [mrt_pkg::MAC_W-1:0]      req_via_mac,
   input  logic [mrt_pkg::TUN_W-1:0]      req_tunnel_id,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mrt_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_answer,
   output logic [mrt_pkg::TUN_W-1:0]      rsp_found_tunnel,
   output logic [mrt_pkg::CNT_W-1:0]      rsp_removed_count
);

   // Scavenge period in ms; to be written by the user only while the block is idle; not enforced.
   logic [mrt_pkg::INTERVAL_W-1:0] interval_ff, interval_in;

   logic              q_valid, q_pop;
   mrt_pkg::item_type q_item;

   assign interval_in = csr_write_enable ? csr_write_data : interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= mrt_pkg::INTERVAL_RESET;
      end else begin
         interval_ff <= interval_in;
      end
   end

   mrt_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_peer_mac(req_peer_mac),
      .req_via_mac(req_via_mac), .req_tunnel_id(req_tunnel_id),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   mrt_back #(.ADJ_ENTRIES(ADJ_ENTRIES), .ROUTE_ENTRIES(ROUTE_ENTRIES)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .interval(interval_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_answer(rsp_answer),
      .rsp_found_tunnel(rsp_found_tunnel), .rsp_removed_count(rsp_removed_count)
   );

   // The back end must never take an item out of an empty queue.
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, q_pop, q_valid, "pop from empty queue")
   // A returned tunnel only comes with a successful lookup.
   `ASSERT_IMPLIES(a_found_ok, clock, reset, rsp_valid && (rsp_found_tunnel != '0),
      rsp_status == mrt_pkg::ST_OK, "tunnel returned with failing status")
   // A true answer never travels with a tunnel or a removal count.
   `ASSERT_ALWAYS(a_answer_alone, clock, reset,
      !(rsp_valid && rsp_answer) || ((rsp_found_tunnel == '0) && (rsp_removed_count == '0)),
      "answer mixed with other result fields")

endmodule
